// ===== hw/rtl/lmps_pkg.sv =====
// Shared types and constants for the LED matrix plane scan driver.
// No dependencies; imported by lmps_expand and led_matrix_plane_scan.
package lmps_pkg;

    localparam int COLUMN_BITS = 36;
    localparam int ROW_OUT_BITS = 12;
    localparam int PIXEL_BITS = 8;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

    typedef enum logic {
        ST_IDLE,
        ST_PROC
    } state_t;

    localparam logic [0:0] REG_FIRST_PLANE = 1'b0;

    localparam logic [2:0] LAST_PLANE = 3'd7;

    // Thermometer planes for a 3-bit red or green level: planes 1..level lit.
    localparam logic [7:0] RG_PLANES [8] = '{
        8'h00, 8'h02, 8'h06, 8'h0E, 8'h1E, 8'h3E, 8'h7E, 8'hFE
    };

    // Planes for the 2-bit blue level.
    localparam logic [7:0] BLUE_PLANES [4] = '{8'h00, 8'h02, 8'h0E, 8'hFE};

endpackage

// ===== hw/rtl/lmps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lmps_expand.sv =====
// Expands one row of RGB332 pixels into the column drive bits of one plane.
// Depends on lmps_pkg for the plane tables and the column count.
module lmps_expand
    import lmps_pkg::*;
#(
    parameter int PIXEL_COLS = 12
) (
    input  logic [PIXEL_BITS*PIXEL_COLS-1:0] row_data,
    input  logic [2:0]                       plane,
    output logic [COLUMN_BITS-1:0]           column_bits
);

    localparam int LIT_W = 3 * PIXEL_COLS;

    logic [LIT_W-1:0] lit;

    genvar x;
    generate
        for (x = 0; x < PIXEL_COLS; x++)
        begin : g_pix
            logic [7:0] pix;
            logic [7:0] blue_lv;
            logic [7:0] green_lv;
            logic [7:0] red_lv;
            assign pix      = row_data[PIXEL_BITS*x +: PIXEL_BITS];
            assign blue_lv  = BLUE_PLANES[pix[1:0]];
            assign green_lv = RG_PLANES[pix[4:2]];
            assign red_lv   = RG_PLANES[pix[7:5]];
            assign lit[3*x]     = blue_lv[plane];
            assign lit[3*x + 1] = green_lv[plane];
            assign lit[3*x + 2] = red_lv[plane];
        end

        if (LIT_W >= COLUMN_BITS)
        begin : g_trim
            assign column_bits = lit[COLUMN_BITS-1:0];
        end
        else
        begin : g_pad
            assign column_bits = {{(COLUMN_BITS - LIT_W){1'b0}}, lit};
        end
    endgenerate

endmodule

// ===== hw/rtl/led_matrix_plane_scan.sv =====
// LED matrix plane scan driver: one frame row per RAM word, read-modify-write.
// A tick is taken into the payload registers at accept; in ST_PROC the row is read and
// expanded, and the result is registered with the done strobe. Start is taken only in ST_IDLE.
// Reset clears scan row, plane, first_plane and the per-row valid bits, so the
// frame reads dark at once; the receiver cannot stall, results are strobed by done.
// Depends on lmps_pkg, lmps_ram and lmps_expand.
module led_matrix_plane_scan
    import lmps_pkg::*;
#(
    parameter int MATRIX_ROWS = 12,
    parameter int MATRIX_PIXEL_COLS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    opcode,
    input  logic [3:0]              pixel_x,
    input  logic [3:0]              pixel_y,
    input  logic [7:0]              color,
    output logic                    done,
    output logic [3:0]              row_index,
    output logic [ROW_OUT_BITS-1:0] row_onehot,
    output logic [2:0]              plane_index,
    output logic [COLUMN_BITS-1:0]  column_bits,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int ROW_W = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;
    localparam int ROW_DATA_W = PIXEL_BITS * MATRIX_PIXEL_COLS;

    state_t                  state_reg, state_next;
    logic [ROW_W-1:0]        scan_row_reg, scan_row_next;
    logic [2:0]              scan_plane_reg, scan_plane_next;
    logic [2:0]              first_plane_reg;
    logic [MATRIX_ROWS-1:0]  row_valid_reg;
    logic                    op_tick_reg;
    logic                    wr_ok_reg;
    logic [3:0]              px_reg;
    logic [7:0]              color_reg;
    logic [ROW_W-1:0]        addr_reg;
    logic                    done_reg;
    logic [3:0]              row_index_reg;
    logic [ROW_OUT_BITS-1:0] row_onehot_reg;
    logic [2:0]              plane_index_reg;
    logic [COLUMN_BITS-1:0]  column_bits_reg;

    logic                    accept;
    logic                    cfg_write;
    logic [ROW_W-1:0]        rd_addr;
    logic [ROW_DATA_W-1:0]   ram_rdata;
    logic [ROW_DATA_W-1:0]   row_data;
    logic [ROW_DATA_W-1:0]   row_mod;
    logic                    ram_we;
    logic [COLUMN_BITS-1:0]  expanded;
    logic [ROW_OUT_BITS-1:0] onehot;
    logic                    in_frame;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg == ST_PROC);

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_FIRST_PLANE) ? {29'd0, first_plane_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_plane_reg <= 3'd0;
        end
        else if (cfg_write && (paddr[2] == REG_FIRST_PLANE))
        begin
            first_plane_reg <= pwdata[2:0];
        end
    end

    // Scan advance happens at accept so the RAM read targets the new row
    always_comb
    begin
        scan_row_next   = scan_row_reg;
        scan_plane_next = scan_plane_reg;
        if (accept && (opcode_t'(opcode) == OP_TICK))
        begin
            if (scan_plane_reg == LAST_PLANE)
            begin
                scan_plane_next = first_plane_reg;
                if ((32'(scan_row_reg) + 1) >= MATRIX_ROWS)
                begin
                    scan_row_next = '0;
                end
                else
                begin
                    scan_row_next = scan_row_reg + ROW_W'(1);
                end
            end
            else
            begin
                scan_plane_next = scan_plane_reg + 3'd1;
            end
        end
    end

    assign in_frame = (32'(pixel_x) < MATRIX_PIXEL_COLS) && (32'(pixel_y) < MATRIX_ROWS);
    assign rd_addr  = (opcode_t'(opcode) == OP_TICK) ? scan_row_next : ROW_W'(pixel_y);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_PROC;
                end
            end
            ST_PROC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_row_reg   <= '0;
            scan_plane_reg <= 3'd0;
            row_valid_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_row_reg   <= scan_row_next;
            scan_plane_reg <= scan_plane_next;
            done_reg       <= busy && op_tick_reg;
            if (ram_we)
            begin
                row_valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // Transaction payload held through the RAM read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_tick_reg <= (opcode_t'(opcode) == OP_TICK);
            wr_ok_reg   <= in_frame;
            px_reg      <= pixel_x;
            color_reg   <= color;
            addr_reg    <= rd_addr;
        end
    end

    lmps_ram #(
        .WIDTH (ROW_DATA_W),
        .DEPTH (MATRIX_ROWS),
        .ADDR_W(ROW_W)
    ) u_frame (
        .clk  (clk),
        .we   (ram_we),
        .waddr(addr_reg),
        .wdata(row_mod),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    // A row never written reads dark
    assign row_data = row_valid_reg[addr_reg] ? ram_rdata : '0;

    genvar gx;
    generate
        for (gx = 0; gx < MATRIX_PIXEL_COLS; gx++)
        begin : g_mod
            assign row_mod[PIXEL_BITS*gx +: PIXEL_BITS] = (32'(px_reg) == gx)
                ? color_reg : row_data[PIXEL_BITS*gx +: PIXEL_BITS];
        end

        for (gx = 0; gx < ROW_OUT_BITS; gx++)
        begin : g_onehot
            assign onehot[gx] = (32'(addr_reg) == gx);
        end
    endgenerate

    assign ram_we = busy && !op_tick_reg && wr_ok_reg;

    lmps_expand #(
        .PIXEL_COLS(MATRIX_PIXEL_COLS)
    ) u_expand (
        .row_data   (row_data),
        .plane      (scan_plane_reg),
        .column_bits(expanded)
    );

    always_ff @(posedge clk)
    begin
        if (busy && op_tick_reg)
        begin
            row_index_reg   <= 4'(addr_reg);
            row_onehot_reg  <= onehot;
            plane_index_reg <= scan_plane_reg;
            column_bits_reg <= expanded;
        end
    end

    assign done        = done_reg;
    assign row_index   = row_index_reg;
    assign row_onehot  = row_onehot_reg;
    assign plane_index = plane_index_reg;
    assign column_bits = column_bits_reg;

endmodule
